[hw/rtl/gbfp_pkg.sv]
`timescale 1ns / 1ps

package gbfp_pkg;

    // Frame geometry
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;
    localparam logic [7:0] PAYLOAD_LEN = 8'd32;
    localparam logic [7:0] STORE_LIMIT = 8'(STORE_DEPTH);

    // Payload byte positions
    localparam logic [STORE_AW-1:0] LAT_AT   = 5'd0;
    localparam logic [STORE_AW-1:0] LON_AT   = 5'd4;
    localparam logic [STORE_AW-1:0] ALT_AT   = 5'd8;
    localparam logic [STORE_AW-1:0] SPD_AT   = 5'd12;
    localparam logic [STORE_AW-1:0] HDG_AT   = 5'd16;
    localparam logic [STORE_AW-1:0] SATS_AT  = 5'd20;
    localparam logic [STORE_AW-1:0] FIX_AT   = 5'd21;
    localparam logic [STORE_AW-1:0] DATE_AT  = 5'd22;
    localparam logic [STORE_AW-1:0] UTC_AT   = 5'd26;
    localparam logic [STORE_AW-1:0] HDOP_LO  = 5'd30;
    localparam logic [STORE_AW-1:0] HDOP_HI  = 5'd31;

    // Division of the time word by 100: drop two bits, then multiply by
    // ceil(2^35 / 25); exact for every magnitude up to 2^31.
    localparam int UTC_MAG_W   = 30;
    localparam int UTC_RECIP_W = 31;
    localparam int UTC_PROD_W  = UTC_MAG_W + UTC_RECIP_W;
    localparam int UTC_SHIFT   = 35;
    localparam int UTC_QUOT_W  = 25;
    localparam logic [UTC_RECIP_W-1:0] UTC_RECIP = 31'd1374389535;

    // Configuration register indexes
    localparam logic [1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HDR_SECOND = 2'd1;
    localparam logic [1:0] CFG_HDR_THIRD  = 2'd2;

    localparam logic [7:0] HDR_FIRST_RST  = 8'd208;
    localparam logic [7:0] HDR_SECOND_RST = 8'd221;
    localparam logic [7:0] HDR_THIRD_RST  = 8'd32;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SUM_A  = 2'd1,
        ST_SUM_B  = 2'd2,
        ST_NO_FIX = 2'd3
    } t_status;

    typedef logic [STORE_DEPTH-1:0][7:0] t_store;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } t_hdr_cfg;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_frame_evt;

    function automatic logic signed [31:0] le_word(input t_store s,
                                                   input logic [STORE_AW-1:0] at);
        return $signed({s[at + 5'd3], s[at + 5'd2], s[at + 5'd1], s[at]});
    endfunction

endpackage

[hw/rtl/gbfp_payload_store.sv]
`timescale 1ns / 1ps

module gbfp_payload_store (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [gbfp_pkg::STORE_AW-1:0]        i_wr_addr,
    input  logic [7:0]                           i_wr_data,
    output gbfp_pkg::t_store                     o_store
);

    gbfp_pkg::t_store r_store;

    // Payload only: no reset, entries are defined once a frame writes them
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_store = r_store;

endmodule

[hw/rtl/gbfp_frame_fsm.sv]
`timescale 1ns / 1ps

module gbfp_frame_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [7:0]                    i_byte,
    input  gbfp_pkg::t_hdr_cfg            i_hdr,
    input  logic [7:0]                    i_fix_byte,
    output logic                          o_wr_en,
    output logic [gbfp_pkg::STORE_AW-1:0] o_wr_addr,
    output logic                          o_at_check,
    output gbfp_pkg::t_frame_evt          o_evt
);

    typedef enum logic [5:0] {
        S_HUNT    = 6'b000001,
        S_SECOND  = 6'b000010,
        S_THIRD   = 6'b000100,
        S_PAYLOAD = 6'b001000,
        S_CHK_A   = 6'b010000,
        S_CHK_B   = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;
    logic [7:0] r_count, n_count;
    logic [7:0] sum_a_inc;
    logic [7:0] count_inc;
    t_phase     restart;

    assign sum_a_inc = r_sum_a + i_byte;
    assign count_inc = r_count + 8'd1;
    // A rejected header byte may itself open a new frame
    assign restart   = (i_byte == i_hdr.first) ? S_SECOND : S_HUNT;

    always_comb begin
        n_phase = r_phase;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_count = r_count;
        o_evt   = '{valid: 1'b0, status: gbfp_pkg::ST_OK};
        o_wr_en = 1'b0;
        if (i_acc) begin
            unique case (r_phase)
                S_SECOND: begin
                    n_phase = (i_byte == i_hdr.second) ? S_THIRD : restart;
                end
                S_THIRD: begin
                    if (i_byte == i_hdr.third) begin
                        n_phase = S_PAYLOAD;
                        n_sum_a = i_byte;
                        n_sum_b = i_byte;
                        n_count = '0;
                    end else begin
                        n_phase = restart;
                    end
                end
                S_PAYLOAD: begin
                    o_wr_en = (r_count < gbfp_pkg::STORE_LIMIT);
                    n_count = count_inc;
                    n_sum_a = sum_a_inc;
                    n_sum_b = r_sum_b + sum_a_inc;
                    if (count_inc == gbfp_pkg::PAYLOAD_LEN) begin
                        n_phase = S_CHK_A;
                    end
                end
                S_CHK_A: begin
                    if (i_byte != r_sum_a) begin
                        n_phase = S_HUNT;
                        o_evt   = '{valid: 1'b1, status: gbfp_pkg::ST_SUM_A};
                    end else begin
                        n_phase = S_CHK_B;
                    end
                end
                S_CHK_B: begin
                    n_phase     = S_HUNT;
                    o_evt.valid = 1'b1;
                    if (i_byte != r_sum_b) begin
                        o_evt.status = gbfp_pkg::ST_SUM_B;
                    end else if (i_fix_byte == 8'd0) begin
                        o_evt.status = gbfp_pkg::ST_NO_FIX;
                    end else begin
                        o_evt.status = gbfp_pkg::ST_OK;
                    end
                end
                default: begin
                    n_phase = restart;
                end
            endcase
        end
    end

    assign o_wr_addr  = r_count[gbfp_pkg::STORE_AW-1:0];
    assign o_at_check = (r_phase == S_CHK_A) || (r_phase == S_CHK_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_HUNT;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/gbfp_utc_div.sv]
`timescale 1ns / 1ps

module gbfp_utc_div (
    input  logic                                    i_clk,
    input  logic signed [31:0]                      i_raw,
    output logic signed [gbfp_pkg::UTC_QUOT_W:0]    o_quot
);

    logic                                   r_neg1, r_neg2;
    logic [gbfp_pkg::UTC_MAG_W-1:0]         r_mag, n_mag;
    logic [gbfp_pkg::UTC_PROD_W-1:0]        r_prod, n_prod;
    logic [31:0]                            abs_raw;
    logic [gbfp_pkg::UTC_QUOT_W-1:0]        quot_mag;
    logic signed [gbfp_pkg::UTC_QUOT_W:0]   r_quot, n_quot;

    // Magnitude, pre-divided by four
    assign abs_raw = i_raw[31] ? (32'd0 - 32'(i_raw)) : 32'(i_raw);
    assign n_mag   = abs_raw[31:2];

    // Divide by 25 through the reciprocal
    assign n_prod = gbfp_pkg::UTC_PROD_W'(r_mag) * gbfp_pkg::UTC_PROD_W'(gbfp_pkg::UTC_RECIP);

    // Truncate toward zero: restore the sign after the unsigned quotient
    assign quot_mag = r_prod[gbfp_pkg::UTC_SHIFT +: gbfp_pkg::UTC_QUOT_W];
    assign n_quot   = r_neg2 ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});

    always_ff @(posedge i_clk) begin
        r_neg1 <= i_raw[31];
        r_mag  <= n_mag;
        r_neg2 <= r_neg1;
        r_prod <= n_prod;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

[hw/rtl/gbfp_result_reg.sv]
`timescale 1ns / 1ps

module gbfp_result_reg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gbfp_pkg::t_frame_evt                 i_evt,
    input  gbfp_pkg::t_store                     i_store,
    input  logic signed [gbfp_pkg::UTC_QUOT_W:0] i_utc,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [1:0]                           o_status,
    output logic signed [31:0]                   o_latitude,
    output logic signed [31:0]                   o_longitude,
    output logic signed [31:0]                   o_altitude,
    output logic signed [31:0]                   o_ground_speed,
    output logic signed [31:0]                   o_heading,
    output logic [7:0]                           o_satellites,
    output logic signed [31:0]                   o_date_word,
    output logic signed [25:0]                   o_utc_time,
    output logic [15:0]                          o_hdop
);

    logic               r_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_lat, r_lon, r_alt, r_spd, r_hdg, r_date;
    logic [7:0]         r_sats;
    logic signed [25:0] r_utc;
    logic [15:0]        r_hdop;
    logic               ok;

    assign ok = (i_evt.status == gbfp_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_evt.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Data fields read as zero on any status other than ok
    always_ff @(posedge i_clk) begin
        if (i_evt.valid) begin
            r_status <= i_evt.status;
            r_lat    <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::LAT_AT)  : '0;
            r_lon    <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::LON_AT)  : '0;
            r_alt    <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::ALT_AT)  : '0;
            r_spd    <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::SPD_AT)  : '0;
            r_hdg    <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::HDG_AT)  : '0;
            r_sats   <= ok ? i_store[gbfp_pkg::SATS_AT] : '0;
            r_date   <= ok ? gbfp_pkg::le_word(i_store, gbfp_pkg::DATE_AT) : '0;
            r_utc    <= ok ? i_utc : '0;
            r_hdop   <= ok ? {i_store[gbfp_pkg::HDOP_HI], i_store[gbfp_pkg::HDOP_LO]} : '0;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_status;
    assign o_latitude     = r_lat;
    assign o_longitude    = r_lon;
    assign o_altitude     = r_alt;
    assign o_ground_speed = r_spd;
    assign o_heading      = r_hdg;
    assign o_satellites   = r_sats;
    assign o_date_word    = r_date;
    assign o_utc_time     = r_utc;
    assign o_hdop         = r_hdop;

endmodule

[hw/rtl/gps_binary_frame_parser.sv]
`timescale 1ns / 1ps

// Byte-serial parser for checksummed binary navigation frames.
// Input channel: one received byte per beat (i_in_valid / o_in_ready).
// The parser hunts for a three-byte header set by the configuration
// registers, stores 32 payload bytes while two 8-bit running sums advance
// from the third header byte, then checks the two checksum bytes.
// Output channel (o_out_valid / i_out_ready): one result per frame, after a
// wrong first checksum byte or after the second checksum byte; status plus
// the navigation fields, which are zero unless the status is ok.
// The result is registered: it is valid the cycle after the beat of the closing byte.
// Throughput: one byte per cycle while o_in_ready is high; the frame state is registered.
// The time-of-day quotient runs through a three-stage divide pipeline off
// the stored bytes; it settles by the first checksum beat, ahead of its use.
// Configuration port: always ready; index 0..2 selects a header byte, any
// other index is ignored. Write only while no frame is in flight.
// Reset (synchronous, active low): hunt for the first header byte, clear the
// sums and count, reload the header bytes 208, 221, 32; drop any result.
// Receiver stall: a pending result is held; bytes keep flowing, except that
// o_in_ready drops while the parser sits on a checksum byte.

module gps_binary_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic signed [31:0] o_altitude,
    output logic signed [31:0] o_ground_speed,
    output logic signed [31:0] o_heading,
    output logic [7:0]         o_satellites,
    output logic signed [31:0] o_date_word,
    output logic signed [25:0] o_utc_time,
    output logic [15:0]        o_hdop,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    gbfp_pkg::t_hdr_cfg                   r_hdr;
    gbfp_pkg::t_store                     store;
    gbfp_pkg::t_frame_evt                 evt;
    logic                                 acc;
    logic                                 wr_en;
    logic [gbfp_pkg::STORE_AW-1:0]        wr_addr;
    logic                                 at_check;
    logic signed [gbfp_pkg::UTC_QUOT_W:0] utc_quot;

    // Header registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.first  <= gbfp_pkg::HDR_FIRST_RST;
            r_hdr.second <= gbfp_pkg::HDR_SECOND_RST;
            r_hdr.third  <= gbfp_pkg::HDR_THIRD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gbfp_pkg::CFG_HDR_FIRST:  r_hdr.first  <= i_cfg_data;
                gbfp_pkg::CFG_HDR_SECOND: r_hdr.second <= i_cfg_data;
                gbfp_pkg::CFG_HDR_THIRD:  r_hdr.third  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Only checksum bytes can raise a result; hold them while one is pending
    assign o_in_ready = !o_out_valid || i_out_ready || !at_check;
    assign acc        = i_in_valid && o_in_ready;

    gbfp_frame_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_byte     (i_rx_byte),
        .i_hdr      (r_hdr),
        .i_fix_byte (store[gbfp_pkg::FIX_AT]),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_at_check (at_check),
        .o_evt      (evt)
    );

    gbfp_payload_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .o_store   (store)
    );

    gbfp_utc_div u_utc_div (
        .i_clk  (i_clk),
        .i_raw  (gbfp_pkg::le_word(store, gbfp_pkg::UTC_AT)),
        .o_quot (utc_quot)
    );

    gbfp_result_reg u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (evt),
        .i_store        (store),
        .i_utc          (utc_quot),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_latitude     (o_latitude),
        .o_longitude    (o_longitude),
        .o_altitude     (o_altitude),
        .o_ground_speed (o_ground_speed),
        .o_heading      (o_heading),
        .o_satellites   (o_satellites),
        .o_date_word    (o_date_word),
        .o_utc_time     (o_utc_time),
        .o_hdop         (o_hdop)
    );

endmodule

[tb/sv/tb_gps_binary_frame_parser.sv]
`timescale 1ns / 1ps

module tb_gps_binary_frame_parser;
    import gbfp_pkg::*;

    // Run shape
    localparam int          CLK_HALF        = 6;
    localparam int          RESET_CYCLES    = 5;
    localparam int          MAX_GAP         = 40;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          TAIL_CYCLES     = 12;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          PRESSURE_FRAMES = 5;
    localparam int unsigned BEATS_PER_PHASE = 150;
    localparam int unsigned FIXES_PER_PHASE = 8;
    localparam int          N_PHASES        = 5;
    localparam int          CYCLE_LIMIT     = 500000;

    // Index outside the register map; writes to it must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Where the parser stands in a frame
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_WANT_SECOND,
        PH_WANT_THIRD,
        PH_BODY,
        PH_CHECK_A,
        PH_CHECK_B
    } frame_phase_e;

    // Shapes of byte sequence offered to the parser
    typedef enum logic [2:0] {
        FK_GOOD,
        FK_BAD_A,
        FK_BAD_B,
        FK_NOFIX,
        FK_SECOND_MISS,
        FK_THIRD_MISS,
        FK_TRUNC,
        FK_NOISE
    } frame_kind_e;

    typedef enum logic [2:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_MAX,
        FILL_MIN
    } fill_e;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic signed [31:0] ground_speed;
        logic signed [31:0] heading;
        logic [7:0]         satellites;
        logic signed [31:0] date_word;
        logic signed [25:0] utc_time;
        logic [15:0]        hdop;
    } nav_result_t;

    typedef logic [7:0] body_t [STORE_DEPTH];

    typedef struct {
        frame_kind_e kind;
        fill_e       fill;
        bit          typed;
        t_status     status;
    } directed_row_t;

    typedef struct {
        int unsigned send_pct;
        int unsigned recv_pct;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [7:0]  third;
    } phase_plan_t;

    // Directed frames. Rows marked typed carry an expectation that can be
    // read straight off the frame; the typed ok row is the all-ones payload.
    directed_row_t directed_rows [12] = '{
        '{FK_GOOD,        FILL_ONES,   1'b1, ST_OK},
        '{FK_GOOD,        FILL_ZERO,   1'b1, ST_NO_FIX},
        '{FK_BAD_A,       FILL_RANDOM, 1'b1, ST_SUM_A},
        '{FK_BAD_B,       FILL_RANDOM, 1'b1, ST_SUM_B},
        '{FK_NOFIX,       FILL_RANDOM, 1'b1, ST_NO_FIX},
        '{FK_GOOD,        FILL_MAX,    1'b0, ST_OK},
        '{FK_GOOD,        FILL_MIN,    1'b0, ST_OK},
        '{FK_SECOND_MISS, FILL_RANDOM, 1'b0, ST_OK},
        '{FK_THIRD_MISS,  FILL_RANDOM, 1'b0, ST_OK},
        '{FK_GOOD,        FILL_RANDOM, 1'b0, ST_OK},
        '{FK_NOISE,       FILL_RANDOM, 1'b0, ST_OK},
        '{FK_TRUNC,       FILL_RANDOM, 1'b0, ST_OK}
    };

    // Idle mix and header bytes per phase; the last phase draws its headers
    phase_plan_t phase_plan [N_PHASES] = '{
        '{0,  0,  HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST},
        '{85, 0,  8'h00,         8'hFF,          8'h00},
        '{0,  85, 8'hFF,         8'h00,          8'hFF},
        '{15, 15, 8'hAA,         8'hAA,          8'hAA},
        '{15, 15, 8'h00,         8'h00,          8'h00}
    };

    // DUT inputs, known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = CFG_HDR_FIRST;
    logic [7:0] i_cfg_data  = 8'h00;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_latitude;
    logic signed [31:0] o_longitude;
    logic signed [31:0] o_altitude;
    logic signed [31:0] o_ground_speed;
    logic signed [31:0] o_heading;
    logic [7:0]         o_satellites;
    logic signed [31:0] o_date_word;
    logic signed [25:0] o_utc_time;
    logic [15:0]        o_hdop;
    logic               o_cfg_ready;

    // Parser mirror: header registers, frame position, sums and payload
    logic [7:0]   hdr_first  = HDR_FIRST_RST;
    logic [7:0]   hdr_second = HDR_SECOND_RST;
    logic [7:0]   hdr_third  = HDR_THIRD_RST;
    frame_phase_e frame_phase = PH_HUNT;
    logic [7:0]   csum_a     = 8'h00;
    logic [7:0]   csum_b     = 8'h00;
    logic [7:0]   body_count = 8'h00;
    logic [7:0]   body_store [STORE_DEPTH];

    // Navigation results still owed by the DUT, oldest first
    nav_result_t pending_fixes [$];
    nav_result_t typed_fix;
    bit          typed_armed = 1'b0;

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned useful_beats    = 0;
    int unsigned fixes_predicted = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned hold_trig       = 0;
    int unsigned hold_seen       = 0;
    int unsigned hold_left       = 0;

    gps_binary_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_latitude     (o_latitude),
        .o_longitude    (o_longitude),
        .o_altitude     (o_altitude),
        .o_ground_speed (o_ground_speed),
        .o_heading      (o_heading),
        .o_satellites   (o_satellites),
        .o_date_word    (o_date_word),
        .o_utc_time     (o_utc_time),
        .o_hdop         (o_hdop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_gps_binary_frame_parser: FAIL");
            $finish;
        end
    end

    // Little-endian word from the mirrored payload
    function automatic logic [31:0] store_word(input logic [STORE_AW-1:0] at);
        return {body_store[at + 5'd3], body_store[at + 5'd2],
                body_store[at + 5'd1], body_store[at]};
    endfunction

    // Advance the mirror by one accepted byte; return 1 when a frame closes
    function automatic bit advance_parser(input logic [7:0] b, output nav_result_t r);
        logic signed [31:0] utc_raw;
        bit                 closed;
        r      = '0;
        closed = 1'b0;
        case (frame_phase)
            PH_WANT_SECOND: begin
                if (b == hdr_second) begin
                    frame_phase = PH_WANT_THIRD;
                end else begin
                    // a wrong second byte may itself open a new frame
                    frame_phase = (b == hdr_first) ? PH_WANT_SECOND : PH_HUNT;
                end
            end
            PH_WANT_THIRD: begin
                if (b == hdr_third) begin
                    frame_phase = PH_BODY;
                    csum_a      = b;
                    csum_b      = b;
                    body_count  = 8'h00;
                end else begin
                    frame_phase = (b == hdr_first) ? PH_WANT_SECOND : PH_HUNT;
                end
            end
            PH_BODY: begin
                if (body_count < STORE_LIMIT) body_store[body_count[STORE_AW-1:0]] = b;
                body_count = body_count + 8'd1;
                csum_a     = csum_a + b;
                csum_b     = csum_b + csum_a;
                if (body_count == PAYLOAD_LEN) frame_phase = PH_CHECK_A;
            end
            PH_CHECK_A: begin
                if (csum_a != b) begin
                    frame_phase = PH_HUNT;
                    r.status    = ST_SUM_A;
                    closed      = 1'b1;
                end else begin
                    frame_phase = PH_CHECK_B;
                end
            end
            PH_CHECK_B: begin
                frame_phase = PH_HUNT;
                closed      = 1'b1;
                if (csum_b != b) begin
                    r.status = ST_SUM_B;
                end else if (body_store[FIX_AT] == 8'h00) begin
                    r.status = ST_NO_FIX;
                end else begin
                    r.status       = ST_OK;
                    r.latitude     = store_word(LAT_AT);
                    r.longitude    = store_word(LON_AT);
                    r.altitude     = store_word(ALT_AT);
                    r.ground_speed = store_word(SPD_AT);
                    r.heading      = store_word(HDG_AT);
                    r.satellites   = body_store[SATS_AT];
                    r.date_word    = store_word(DATE_AT);
                    // signed division truncates toward zero
                    utc_raw        = store_word(UTC_AT);
                    r.utc_time     = 26'(utc_raw / 32'sd100);
                    r.hdop         = {body_store[HDOP_HI], body_store[HDOP_LO]};
                end
            end
            default: begin
                frame_phase = (b == hdr_first) ? PH_WANT_SECOND : PH_HUNT;
            end
        endcase
        return closed;
    endfunction

    // Offer one byte after a random idle gap, hold it until accepted, then
    // advance the mirror and queue any result the byte closes
    task automatic send_byte(input logic [7:0] b);
        nav_result_t r;
        int          gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        // a byte in hunt that opens nothing is merely dropped
        if (frame_phase != PH_HUNT || b == hdr_first) useful_beats++;
        if (advance_parser(b, r)) begin
            pending_fixes.push_back(typed_armed ? typed_fix : r);
            typed_armed = 1'b0;
            fixes_predicted++;
        end
    endtask

    function automatic body_t make_body(input fill_e fill, input frame_kind_e kind);
        body_t body;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            case (fill)
                FILL_ZERO: body[i] = 8'h00;
                FILL_ONES: body[i] = 8'hFF;
                // top byte of every word field gets the sign pattern
                FILL_MAX:  body[i] = (i inside {3, 7, 11, 15, 19, 25, 29}) ? 8'h7F : 8'hFF;
                FILL_MIN:  body[i] = (i inside {3, 7, 11, 15, 19, 25, 29}) ? 8'h80 : 8'h00;
                default: begin
                    case ($urandom_range(9))
                        0:       body[i] = 8'h00;
                        1:       body[i] = 8'hFF;
                        default: body[i] = 8'($urandom);
                    endcase
                end
            endcase
        end
        // keep the fix flag set for the negative extreme, clear it for no fix
        if (fill == FILL_MIN) body[FIX_AT] = 8'h01;
        if (kind == FK_NOFIX) body[FIX_AT] = 8'h00;
        return body;
    endfunction

    task automatic send_frame(input frame_kind_e kind, input body_t body);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int         cut;
        ck_a = hdr_third;
        ck_b = hdr_third;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
        end
        cut = (kind == FK_TRUNC) ? int'($urandom_range(STORE_DEPTH - 1, 1)) : STORE_DEPTH;
        send_byte(hdr_first);
        // a broken header whose bad byte is a fresh first header byte
        if (kind == FK_SECOND_MISS) send_byte(hdr_first);
        if (kind == FK_THIRD_MISS) begin
            send_byte(hdr_second);
            send_byte(hdr_first);
        end
        send_byte(hdr_second);
        send_byte(hdr_third);
        for (int i = 0; i < cut; i++) send_byte(body[i]);
        if (kind != FK_TRUNC) begin
            send_byte(kind == FK_BAD_A ? ck_a ^ 8'($urandom_range(255, 1)) : ck_a);
            send_byte(kind == FK_BAD_B ? ck_b ^ 8'($urandom_range(255, 1)) : ck_b);
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(($urandom_range(3) == 0) ? hdr_first : 8'($urandom));
        end
    endtask

    // Push the parser back to hunting so that the headers may be rewritten
    task automatic drain_to_hunt();
        logic [7:0] b;
        while (frame_phase != PH_HUNT) begin
            b = 8'($urandom);
            case (frame_phase)
                PH_WANT_SECOND: begin
                    while (b == hdr_first || b == hdr_second) b = 8'($urandom);
                end
                PH_WANT_THIRD: begin
                    while (b == hdr_first || b == hdr_third) b = 8'($urandom);
                end
                PH_CHECK_A: b = csum_a ^ 8'h01;
                default: ;
            endcase
            send_byte(b);
        end
    endtask

    // One register beat; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HDR_FIRST:  hdr_first  = val;
            CFG_HDR_SECOND: hdr_second = val;
            CFG_HDR_THIRD:  hdr_third  = val;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        nav_result_t want;
        if (pending_fixes.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual status %0d", $time, o_status);
            return;
        end
        want = pending_fixes.pop_front();
        check_field("status",       32'(want.status),       32'(o_status));
        check_field("latitude",     want.latitude,          o_latitude);
        check_field("longitude",    want.longitude,         o_longitude);
        check_field("altitude",     want.altitude,          o_altitude);
        check_field("ground_speed", want.ground_speed,      o_ground_speed);
        check_field("heading",      want.heading,           o_heading);
        check_field("satellites",   32'(want.satellites),   32'(o_satellites));
        check_field("date_word",    want.date_word,         o_date_word);
        check_field("utc_time",     32'(want.utc_time),     32'(o_utc_time));
        check_field("hdop",         32'(want.hdop),         32'(o_hdop));
    endtask

    // Receiver: check each result beat, then stall at random or for a long
    // hold-off whenever the stimulus asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (hold_seen != hold_trig) begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus
    initial begin
        int          ph;
        int unsigned pick;
        int unsigned beats_mark;
        int unsigned fixes_mark;
        frame_kind_e kind;
        fill_e       fill;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset header bytes, no idling
        foreach (directed_rows[i]) begin
            typed_fix        = '0;
            typed_fix.status = directed_rows[i].status;
            if (directed_rows[i].status == ST_OK) begin
                // all-ones payload: every word reads -1, time of day rounds to zero
                typed_fix.latitude     = '1;
                typed_fix.longitude    = '1;
                typed_fix.altitude     = '1;
                typed_fix.ground_speed = '1;
                typed_fix.heading      = '1;
                typed_fix.satellites   = 8'hFF;
                typed_fix.date_word    = '1;
                typed_fix.hdop         = 16'hFFFF;
            end
            typed_armed = directed_rows[i].typed;
            if (directed_rows[i].kind == FK_NOISE) begin
                send_noise(6);
            end else begin
                send_frame(directed_rows[i].kind,
                           make_body(directed_rows[i].fill, directed_rows[i].kind));
            end
        end
        drain_to_hunt();

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) begin
                phase_plan[ph].first  = 8'($urandom);
                phase_plan[ph].second = 8'($urandom);
                phase_plan[ph].third  = 8'($urandom);
            end
            if (ph != 0) begin
                // Quiesce the input, let every result out, then reprogram
                i_in_valid <= 1'b0;
                while (pending_fixes.size() != 0) @(posedge i_clk);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_reg(CFG_HDR_FIRST,  phase_plan[ph].first);
                write_reg(CFG_HDR_SECOND, phase_plan[ph].second);
                write_reg(CFG_HDR_THIRD,  phase_plan[ph].third);
                write_reg(CFG_UNUSED,     8'($urandom));
                i_cfg_valid <= 1'b0;
            end
            send_idle_pct  = phase_plan[ph].send_pct;
            recv_stall_pct = phase_plan[ph].recv_pct;

            if (ph == 0) begin
                // Hold the receiver off and keep offering frames back to back
                // until the parser fills up and stalls its input
                hold_trig++;
                for (int f = 0; f < PRESSURE_FRAMES; f++) begin
                    send_frame(FK_GOOD, make_body(FILL_RANDOM, FK_GOOD));
                end
            end

            beats_mark = useful_beats;
            fixes_mark = fixes_predicted;
            while (useful_beats - beats_mark < BEATS_PER_PHASE ||
                   fixes_predicted - fixes_mark < FIXES_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 50)      kind = FK_GOOD;
                else if (pick < 60) kind = FK_BAD_A;
                else if (pick < 70) kind = FK_BAD_B;
                else if (pick < 77) kind = FK_NOFIX;
                else if (pick < 83) kind = FK_SECOND_MISS;
                else if (pick < 89) kind = FK_THIRD_MISS;
                else if (pick < 94) kind = FK_TRUNC;
                else                kind = FK_NOISE;
                case ($urandom_range(19))
                    0:       fill = FILL_ZERO;
                    1:       fill = FILL_ONES;
                    2:       fill = FILL_MAX;
                    3:       fill = FILL_MIN;
                    default: fill = FILL_RANDOM;
                endcase
                if (kind == FK_NOISE) send_noise($urandom_range(8, 1));
                else                  send_frame(kind, make_body(fill, kind));
            end
            drain_to_hunt();
        end

        // Drain the remaining results and watch for strays
        i_in_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_gps_binary_frame_parser: PASS");
        end else begin
            $display("tb_gps_binary_frame_parser: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/gbfp_pkg.sv
hw/rtl/gbfp_payload_store.sv
hw/rtl/gbfp_frame_fsm.sv
hw/rtl/gbfp_utc_div.sv
hw/rtl/gbfp_result_reg.sv
hw/rtl/gps_binary_frame_parser.sv
tb/sv/tb_gps_binary_frame_parser.sv
